>>> hdl/bag_sampler_with_out_of_bag_core_defines.svh
// ---------------------------------------------------------------------------
// Bag sampler assertion macros
// Shared property wrappers clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef BAG_SAMPLER_WITH_OUT_OF_BAG_CORE_DEFINES_SVH
`define BAG_SAMPLER_WITH_OUT_OF_BAG_CORE_DEFINES_SVH

// Check an expression on every clock edge
`define BSOOB_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check a consequence in the same cycle
`define BSOOB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the next cycle
`define BSOOB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/bsoob_pkg.sv
// ---------------------------------------------------------------------------
// Bag sampler package
// Sizes, codes, payload types and controller/datapath interface types.
// ---------------------------------------------------------------------------
package bsoob_pkg;

	localparam int MAX_ITEMS = 4096;
	localparam int IDX_W     = $clog2(MAX_ITEMS);
	localparam int CNT_W     = IDX_W + 1;
	localparam int RAND_W    = 32;
	localparam int PROD_W    = RAND_W + CNT_W;

	// In-bag map rows: 32 flags per row
	localparam int MAP_SEL_W  = 5;
	localparam int MAP_ROW_W  = 1 << MAP_SEL_W;
	localparam int MAP_ROWS   = MAX_ITEMS / MAP_ROW_W;
	localparam int MAP_ADDR_W = IDX_W - MAP_SEL_W;

	// Index table rows: 16 entries per row
	localparam int TBL_SEL_W  = 4;
	localparam int TBL_ROW_N  = 1 << TBL_SEL_W;
	localparam int TBL_ROWS   = MAX_ITEMS / TBL_ROW_N;
	localparam int TBL_ADDR_W = IDX_W - TBL_SEL_W;

	// Request actions
	localparam int ACT_W = 2;
	localparam logic [ACT_W-1:0] ACT_RESTART = 2'd0;
	localparam logic [ACT_W-1:0] ACT_DRAW    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_LIST    = 2'd2;

	// Configuration registers
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLING_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ITEM_COUNT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT  = 2'd2;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [RAND_W-1:0] random_fraction;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0] item_index;
		logic             index_valid;
		logic [CNT_W-1:0] out_of_bag_count;
		logic             run_done;
	} rsp_t;

	typedef logic [TBL_ROW_N-1:0][IDX_W-1:0] tbl_row_t;

	// Controller commands to the datapath
	typedef struct packed {
		logic load;
		logic restart;
		logic draw_rd;
		logic draw_wb;
		logic list_rd;
		logic list_chk;
		logic put_none;
		logic put_done;
	} cmd_t;

	// Datapath status to the controller
	typedef struct packed {
		logic out_free;
		logic draw_exh;
		logic cursor_end;
		logic list_more;
	} sts_t;

endpackage

>>> hdl/bag_sampler_with_out_of_bag_core.sv
// ---------------------------------------------------------------------------
// Bag sampler with out-of-bag listing
// Bootstrap and subsample draws of training item indices, with an in-bag
// map and ascending listing of out-of-bag items.
// ---------------------------------------------------------------------------
//  channel   signals                                  dir  handshake
//  req       req_valid, req_stall, req                in   valid / stall
//  rsp       rsp_valid, rsp_stall, rsp                out  valid / stall
//  cfg       cfg_valid, cfg_ready, cfg_index, cfg_data in  valid / ready
//
//  Restart, unknown action, exhausted draw and listing with the cursor at the
//  end go straight to a finishing step; a draw multiplies at accept, reads
//  the row, then writes it back; a listing reads and checks each 32-item map
//  row visited, paced by the registered read of the map and table rows.
//  Reset is asynchronous; restart drops every row-written flag at once,
//  so no clearing pass runs. A held result does not block the next request;
//  only the finishing step waits for the result register to free up.
// ---------------------------------------------------------------------------
`include "bag_sampler_with_out_of_bag_core_defines.svh"

module bag_sampler_with_out_of_bag_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  bsoob_pkg::req_t                 req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output bsoob_pkg::rsp_t                 rsp,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bsoob_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bsoob_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bsoob_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Accept register writes at any time
	assign cfg_ready = 1'b1;

	bsoob_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.action    (req.action),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bsoob_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// At most one datapath command per cycle
	`BSOOB_ASSERT(a_cmd_onehot, $onehot0(cmd), "more than one datapath command")
	// One request in flight at a time
	`BSOOB_ASSERT_NEXT(a_one_req, req_valid && !req_stall, req_stall, "request taken twice")
	// A result never claims both an index and exhaustion
	`BSOOB_ASSERT_IMP(a_rsp_kind, rsp_valid && rsp.index_valid, !rsp.run_done, "index with done")
	// Without an index the index field is zero
	`BSOOB_ASSERT_IMP(a_rsp_zero, rsp_valid && !rsp.index_valid, rsp.item_index == '0, "bad empty result")
	// The out-of-bag count stays in range
	`BSOOB_ASSERT_IMP(a_rsp_count, rsp_valid, rsp.out_of_bag_count <= CNT_W'(MAX_ITEMS), "bad count")

endmodule

>>> hdl/bsoob_ctrl.sv
// ---------------------------------------------------------------------------
// Bag sampler controller
// Sequences restart, draw and out-of-bag listing steps over the datapath.
// ---------------------------------------------------------------------------
module bsoob_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic [bsoob_pkg::ACT_W-1:0] action,
	output logic                       req_stall,
	input  bsoob_pkg::sts_t            sts,
	output bsoob_pkg::cmd_t            cmd
);
	import bsoob_pkg::*;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_RESTART  = 3'd1;
	localparam logic [2:0] ST_NONE     = 3'd2;
	localparam logic [2:0] ST_DRAW_RD  = 3'd3;
	localparam logic [2:0] ST_DRAW_WB  = 3'd4;
	localparam logic [2:0] ST_LIST_RD  = 3'd5;
	localparam logic [2:0] ST_LIST_CHK = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Take a new request only when idle
	assign req_stall = (state_q != ST_IDLE);

	// Decode next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					unique case (action)
						ACT_RESTART: state_d = ST_RESTART;
						ACT_DRAW:    state_d = ST_DRAW_RD;
						ACT_LIST:    state_d = ST_LIST_RD;
						default:     state_d = ST_NONE;
					endcase
				end
			end
			ST_RESTART: begin
				if (sts.out_free) begin
					cmd.restart = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_NONE: begin
				if (sts.out_free) begin
					cmd.put_none = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_DRAW_RD: begin
				if (!sts.draw_exh) begin
					cmd.draw_rd = 1'b1;
					state_d     = ST_DRAW_WB;
				end else if (sts.out_free) begin
					cmd.put_done = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_DRAW_WB: begin
				if (sts.out_free) begin
					cmd.draw_wb = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_LIST_RD: begin
				if (!sts.cursor_end) begin
					cmd.list_rd = 1'b1;
					state_d     = ST_LIST_CHK;
				end else if (sts.out_free) begin
					cmd.put_done = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_LIST_CHK: begin
				if (sts.list_more) begin
					cmd.list_chk = 1'b1;
					state_d      = ST_LIST_RD;
				end else if (sts.out_free) begin
					cmd.list_chk = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hdl/bsoob_dpath.sv
// ---------------------------------------------------------------------------
// Bag sampler datapath
// Config registers, scaling multiplier, in-bag map and index table rows,
// counters, out-of-bag scan and the result register.
// ---------------------------------------------------------------------------
module bsoob_dpath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bsoob_pkg::req_t                 req,
	input  logic                            cfg_valid,
	input  logic [bsoob_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bsoob_pkg::CFG_DATA_W-1:0] cfg_data,
	input  bsoob_pkg::cmd_t                 cmd,
	output bsoob_pkg::sts_t                 sts,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output bsoob_pkg::rsp_t                 rsp
);
	import bsoob_pkg::*;

	// Configuration
	logic             mode_q;
	logic [CNT_W-1:0] item_count_q;
	logic [CNT_W-1:0] sample_count_q;

	// Run state
	logic [CNT_W-1:0] draw_q;
	logic [CNT_W-1:0] missing_q;
	logic [CNT_W-1:0] cursor_q;

	// Draw operands
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] last_q;

	// In-bag map storage
	logic [MAP_ROW_W-1:0] map_mem [MAP_ROWS];
	logic [MAP_ROWS-1:0]  map_rv_q;
	logic [MAP_ROW_W-1:0] map_rd_q;
	logic                 map_rdv_q;

	// Index table storage
	tbl_row_t            tbl_mem [TBL_ROWS];
	logic [TBL_ROWS-1:0] tbl_rv_q;
	tbl_row_t            tbl_a_q;
	tbl_row_t            tbl_b_q;
	logic                tbl_a_v_q;
	logic                tbl_b_v_q;

	// Result register
	logic rsp_valid_q;
	rsp_t rsp_q;
	rsp_t rsp_d;
	logic push;

	logic [CNT_W-1:0]      n_eff;
	logic [CNT_W-1:0]      s_eff;
	logic [CNT_W-1:0]      range_w;
	logic [PROD_W-1:0]     prod;
	logic [MAP_ADDR_W-1:0] map_raddr;
	logic [MAP_ADDR_W-1:0] j_map_row;
	logic [TBL_ADDR_W-1:0] j_tbl_row;
	logic [TBL_ADDR_W-1:0] last_tbl_row;
	logic [MAP_ROW_W-1:0]  map_eff;
	logic [MAP_ROW_W-1:0]  map_wdata;
	logic                  map_we;
	logic                  bit_was;
	logic [CNT_W-1:0]      missing_next;
	tbl_row_t              tbl_a_eff;
	tbl_row_t              tbl_b_eff;
	tbl_row_t              tbl_wdata;
	logic                  tbl_we;
	logic [IDX_W-1:0]      entry_j;
	logic [IDX_W-1:0]      entry_last;
	logic [MAP_ROW_W-1:0]  low_mask;
	logic [MAP_ROW_W-1:0]  free_bits;
	logic [MAP_ROW_W-1:0]  first_free;
	logic [MAP_SEL_W-1:0]  free_pos;
	logic                  any_free;
	logic [IDX_W-1:0]      scan_pos;
	logic                  scan_hit;
	logic [CNT_W-MAP_SEL_W-1:0] next_row;
	logic [CNT_W-1:0]      next_start;
	logic                  list_more;

	function automatic tbl_row_t ident_row(input logic [TBL_ADDR_W-1:0] row);
		tbl_row_t r;
		for (int k = 0; k < TBL_ROW_N; k++) begin
			r[k] = {row, TBL_SEL_W'(k)};
		end
		return r;
	endfunction

	// Clamp item count to 1..MAX_ITEMS, sample limit to at most that
	always_comb begin
		if (item_count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (item_count_q > CNT_W'(MAX_ITEMS)) begin
			n_eff = CNT_W'(MAX_ITEMS);
		end else begin
			n_eff = item_count_q;
		end
		s_eff = (sample_count_q < n_eff) ? sample_count_q : n_eff;
	end

	// Scale the random fraction into the draw range
	assign range_w = mode_q ? (n_eff - draw_q) : n_eff;
	assign prod    = PROD_W'(req.random_fraction) * PROD_W'(range_w);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			j_q    <= prod[RAND_W +: IDX_W];
			last_q <= IDX_W'(range_w - CNT_W'(1));
		end
	end

	assign j_map_row    = j_q[IDX_W-1:MAP_SEL_W];
	assign j_tbl_row    = j_q[IDX_W-1:TBL_SEL_W];
	assign last_tbl_row = last_q[IDX_W-1:TBL_SEL_W];
	assign map_raddr    = cmd.list_rd ? cursor_q[IDX_W-1:MAP_SEL_W] : j_map_row;

	// In-bag map: unwritten rows read as all clear
	assign map_eff      = map_rdv_q ? map_rd_q : '0;
	assign bit_was      = map_eff[j_q[MAP_SEL_W-1:0]];
	assign map_wdata    = map_eff | (MAP_ROW_W'(1) << j_q[MAP_SEL_W-1:0]);
	assign map_we       = cmd.draw_wb && !mode_q;
	assign missing_next = (!bit_was && (missing_q != '0)) ? (missing_q - CNT_W'(1)) : missing_q;

	always_ff @(posedge clk) begin
		if (cmd.draw_rd || cmd.list_rd) begin
			map_rd_q  <= map_mem[map_raddr];
			map_rdv_q <= map_rv_q[map_raddr];
		end
		if (map_we) begin
			map_mem[j_map_row] <= map_wdata;
		end
	end

	// Index table: unwritten rows read as identity
	assign tbl_a_eff  = tbl_a_v_q ? tbl_a_q : ident_row(j_tbl_row);
	assign tbl_b_eff  = tbl_b_v_q ? tbl_b_q : ident_row(last_tbl_row);
	assign entry_j    = tbl_a_eff[j_q[TBL_SEL_W-1:0]];
	assign entry_last = tbl_b_eff[last_q[TBL_SEL_W-1:0]];
	assign tbl_we     = cmd.draw_wb && mode_q;

	always_comb begin
		tbl_wdata = tbl_a_eff;
		tbl_wdata[j_q[TBL_SEL_W-1:0]] = entry_last;
	end

	always_ff @(posedge clk) begin
		if (cmd.draw_rd) begin
			tbl_a_q   <= tbl_mem[j_tbl_row];
			tbl_b_q   <= tbl_mem[last_tbl_row];
			tbl_a_v_q <= tbl_rv_q[j_tbl_row];
			tbl_b_v_q <= tbl_rv_q[last_tbl_row];
		end
		if (tbl_we) begin
			tbl_mem[j_tbl_row] <= tbl_wdata;
		end
	end

	// Row written flags: drop all on restart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_rv_q <= '0;
			tbl_rv_q <= '0;
		end else if (cmd.restart) begin
			map_rv_q <= '0;
			tbl_rv_q <= '0;
		end else begin
			if (map_we) begin
				map_rv_q[j_map_row] <= 1'b1;
			end
			if (tbl_we) begin
				tbl_rv_q[j_tbl_row] <= 1'b1;
			end
		end
	end

	// Find the lowest clear flag at or above the cursor in the fetched row
	assign low_mask   = (MAP_ROW_W'(1) << cursor_q[MAP_SEL_W-1:0]) - MAP_ROW_W'(1);
	assign free_bits  = ~(map_eff | low_mask);
	assign first_free = free_bits & (~free_bits + MAP_ROW_W'(1));
	assign any_free   = |free_bits;

	always_comb begin
		free_pos = '0;
		for (int k = 0; k < MAP_ROW_W; k++) begin
			if (first_free[k]) begin
				free_pos = free_pos | MAP_SEL_W'(k);
			end
		end
	end

	assign scan_pos   = {cursor_q[IDX_W-1:MAP_SEL_W], free_pos};
	assign scan_hit   = any_free && ({1'b0, scan_pos} < n_eff);
	assign next_row   = {1'b0, cursor_q[IDX_W-1:MAP_SEL_W]} + (CNT_W-MAP_SEL_W)'(1);
	assign next_start = {next_row, {MAP_SEL_W{1'b0}}};
	assign list_more  = !any_free && (next_start < n_eff);

	// Status to the controller
	assign sts.out_free   = !rsp_valid_q || !rsp_stall;
	assign sts.draw_exh   = mode_q ? (draw_q >= s_eff) : (draw_q >= n_eff);
	assign sts.cursor_end = (cursor_q >= n_eff);
	assign sts.list_more  = list_more;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= 1'b0;
			item_count_q   <= CNT_W'(MAX_ITEMS);
			sample_count_q <= CNT_W'(MAX_ITEMS);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SAMPLING_MODE: mode_q         <= cfg_data[0];
				CFG_ITEM_COUNT:    item_count_q   <= CNT_W'(cfg_data);
				CFG_SAMPLE_COUNT:  sample_count_q <= CNT_W'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// Counters and scan cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_q    <= '0;
			missing_q <= CNT_W'(MAX_ITEMS);
			cursor_q  <= '0;
		end else begin
			priority if (cmd.restart) begin
				draw_q    <= '0;
				missing_q <= n_eff;
				cursor_q  <= '0;
			end else if (cmd.draw_wb) begin
				draw_q <= draw_q + CNT_W'(1);
				if (!mode_q) begin
					missing_q <= missing_next;
				end
			end else if (cmd.list_chk) begin
				if (scan_hit) begin
					cursor_q <= {1'b0, scan_pos} + CNT_W'(1);
				end else if (list_more) begin
					cursor_q <= next_start;
				end else begin
					cursor_q <= n_eff;
				end
			end
		end
	end

	// Form the result
	assign push = cmd.restart || cmd.draw_wb || cmd.put_none || cmd.put_done
		|| (cmd.list_chk && !list_more);

	always_comb begin
		rsp_d = '0;
		rsp_d.out_of_bag_count = missing_q;
		priority if (cmd.restart) begin
			rsp_d.out_of_bag_count = n_eff;
		end else if (cmd.draw_wb) begin
			rsp_d.item_index  = mode_q ? entry_j : j_q;
			rsp_d.index_valid = 1'b1;
			if (!mode_q) begin
				rsp_d.out_of_bag_count = missing_next;
			end
		end else if (cmd.list_chk) begin
			if (scan_hit) begin
				rsp_d.item_index  = scan_pos;
				rsp_d.index_valid = 1'b1;
			end else begin
				rsp_d.run_done = 1'b1;
			end
		end else if (cmd.put_done) begin
			rsp_d.run_done = 1'b1;
		end else begin
			rsp_d.run_done = 1'b0;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (push) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> test/bag_sampler_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Bag sampler scoreboard
// Tracks the sampler's bag state from accepted requests, predicts one
// result per request and compares the returned results in order.
// ---------------------------------------------------------------------------
package bag_sampler_scoreboard_pkg;

	import bsoob_pkg::*;

	// Codes the design package leaves unnamed
	localparam logic [ACT_W-1:0]     ACT_UNKNOWN = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

	class bag_scoreboard;
		// Register copies
		bit                  subsample;
		logic [CFG_DATA_W-1:0] item_reg;
		logic [CFG_DATA_W-1:0] sample_reg;
		// Bag state
		logic [IDX_W-1:0]    slot_of [MAX_ITEMS];
		bit                  marked [MAX_ITEMS];
		int unsigned         draws;
		int unsigned         missing;
		int unsigned         cursor;
		rsp_t                expected_answers [$];
		int                  errors;

		function new();
			subsample  = 1'b0;
			item_reg   = 13'd4096;
			sample_reg = 13'd4096;
			errors     = 0;
			restart_bag();
		endfunction

		// Clamp the item count to 1..MAX_ITEMS
		function int unsigned items_in_use();
			if (item_reg == 0) return 1;
			if (item_reg > MAX_ITEMS) return MAX_ITEMS;
			return item_reg;
		endfunction

		// Draws allowed before the run is exhausted
		function int unsigned draw_limit();
			int unsigned n;
			n = items_in_use();
			if (!subsample) return n;
			return (sample_reg < n) ? sample_reg : n;
		endfunction

		function void restart_bag();
			for (int k = 0; k < MAX_ITEMS; k++) begin
				slot_of[k] = k[IDX_W-1:0];
				marked[k]  = 1'b0;
			end
			draws   = 0;
			missing = items_in_use();
			cursor  = 0;
		endfunction

		// floor(r * span / 2^32)
		function int unsigned scale_fraction(logic [RAND_W-1:0] r, int unsigned span);
			longint unsigned prod;
			prod = {32'd0, r} * longint'(span);
			return int'(prod >> 32);
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_SAMPLING_MODE: subsample  = data[0];
				CFG_ITEM_COUNT:    item_reg   = data;
				CFG_SAMPLE_COUNT:  sample_reg = data;
				default: ;
			endcase
		endfunction

		// Advance the bag state for one accepted request and queue its result
		function void note_request(req_t rq);
			rsp_t        want;
			int unsigned n, j, span, c;
			n    = items_in_use();
			want = '0;
			case (rq.action)
				ACT_RESTART: restart_bag();
				ACT_DRAW: begin
					if (draws >= draw_limit()) begin
						want.run_done = 1'b1;
					end else if (!subsample) begin
						j = scale_fraction(rq.random_fraction, n);
						if (!marked[j]) begin
							marked[j] = 1'b1;
							if (missing > 0) missing--;
						end
						want.item_index  = j[IDX_W-1:0];
						want.index_valid = 1'b1;
						draws++;
					end else begin
						// move the last live slot into the chosen one
						span             = n - draws;
						j                = scale_fraction(rq.random_fraction, span);
						want.item_index  = slot_of[j];
						slot_of[j]       = slot_of[span - 1];
						want.index_valid = 1'b1;
						draws++;
					end
				end
				ACT_LIST: begin
					c = cursor;
					while (c < n && marked[c]) c++;
					if (c < n) begin
						want.item_index  = c[IDX_W-1:0];
						want.index_valid = 1'b1;
						cursor           = c + 1;
					end else begin
						if (cursor < n) cursor = n;
						want.run_done = 1'b1;
					end
				end
				default: ;
			endcase
			want.out_of_bag_count = missing[CNT_W-1:0];
			expected_answers.insert(expected_answers.size(), want);
		endfunction

		function void report_field(string field, int unsigned want, int unsigned got);
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			errors++;
		endfunction

		// Compare one returned result with the oldest prediction
		function void check_result(rsp_t got);
			rsp_t want;
			if (expected_answers.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, got);
				errors++;
				return;
			end
			want = expected_answers.pop_front();
			if (got.item_index !== want.item_index)
				report_field("item_index", want.item_index, got.item_index);
			if (got.index_valid !== want.index_valid)
				report_field("index_valid", want.index_valid, got.index_valid);
			if (got.out_of_bag_count !== want.out_of_bag_count)
				report_field("out_of_bag_count", want.out_of_bag_count, got.out_of_bag_count);
			if (got.run_done !== want.run_done)
				report_field("run_done", want.run_done, got.run_done);
		endfunction

		function int pending();
			return expected_answers.size();
		endfunction
	endclass

endpackage

>>> test/bag_sampler_with_out_of_bag_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Bag sampler testbench
// Drives restart, draw, listing and unknown requests in bootstrap and subsample
// mode across many register settings, with random sender bursts and
// receiver stalls, and checks every result against a scoreboard.
// ---------------------------------------------------------------------------
module bag_sampler_with_out_of_bag_core_tb;

	import bsoob_pkg::*;
	import bag_sampler_scoreboard_pkg::*;

	localparam int ITEM_TARGET = 1350;
	localparam int IDLE_LIMIT  = 4000;
	localparam int SETTLE      = 8;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  req_valid  = 1'b0;
	logic                  req_stall;
	req_t                  req        = '0;
	logic                  rsp_valid;
	logic                  rsp_stall  = 1'b0;
	rsp_t                  rsp;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	bag_scoreboard sb;
	int            items_sent  = 0;
	int            burst_left  = 0;
	int            stall_left  = 0;
	int            stall_pct   = 0;
	int            idle_cycles = 0;

	bag_sampler_with_out_of_bag_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Receiver: stall rate changes at random intervals
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_left = $urandom_range(20, 200);
			case ($urandom_range(4))
				2: stall_pct = 30;
				3: stall_pct = 60;
				4: stall_pct = 85;
				default: stall_pct = 0;
			endcase
		end else begin
			stall_left--;
		end
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	// Check each accepted result
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_result(rsp);
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [RAND_W-1:0] pick_fraction();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Hold one request until accepted, then maybe open a gap
	task automatic send_request(input logic [ACT_W-1:0] action, input logic [RAND_W-1:0] r);
		req_t item;
		int   gap;
		item.action          = action;
		item.random_fraction = r;
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (req_stall);
		sb.note_request(item);
		if (action != ACT_UNKNOWN) items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 10);
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
	endtask

	// Stop sending and wait for every outstanding result
	task automatic wait_for_idle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_register(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Extremes of the fields and the corner cases of both modes
	task automatic run_directed();
		send_request(ACT_RESTART, $urandom);
		send_request(ACT_DRAW, '0);
		send_request(ACT_DRAW, '1);
		send_request(ACT_DRAW, '0);
		send_request(ACT_LIST, $urandom);
		send_request(ACT_LIST, $urandom);
		send_request(ACT_UNKNOWN, '1);
		wait_for_idle();
		// item count of zero acts as one item
		write_register(CFG_ITEM_COUNT, 13'd0);
		write_register(CFG_UNUSED, 13'h1FFF);
		send_request(ACT_RESTART, '1);
		send_request(ACT_DRAW, '1);
		send_request(ACT_DRAW, $urandom);
		send_request(ACT_LIST, $urandom);
		send_request(ACT_LIST, $urandom);
		wait_for_idle();
		// subsample with no draws allowed, item count above the maximum
		write_register(CFG_SAMPLING_MODE, 13'h1FFF);
		write_register(CFG_ITEM_COUNT, 13'h1FFF);
		write_register(CFG_SAMPLE_COUNT, 13'd0);
		send_request(ACT_DRAW, $urandom);
		wait_for_idle();
		// sample count above item count, walk the table dry
		write_register(CFG_ITEM_COUNT, 13'd3);
		write_register(CFG_SAMPLE_COUNT, 13'd5);
		send_request(ACT_RESTART, '0);
		send_request(ACT_DRAW, '1);
		send_request(ACT_DRAW, '0);
		send_request(ACT_DRAW, '1);
		send_request(ACT_DRAW, $urandom);
		repeat (4) send_request(ACT_LIST, $urandom);
	endtask

	// One register setting followed by a bag run or a burst of noise
	task automatic run_random_phase();
		int unsigned      n_sel, limit, cnt, act_sel;
		logic [CFG_DATA_W-1:0] n_val, s_val;
		logic [ACT_W-1:0] action;
		wait_for_idle();
		n_sel = $urandom_range(99);
		if (n_sel < 5)       n_val = 13'd0;
		else if (n_sel < 10) n_val = 13'($urandom_range(4097, 8191));
		else if (n_sel < 15) n_val = 13'd4096;
		else if (n_sel < 22) n_val = 13'($urandom_range(100, 600));
		else if (n_sel < 28) n_val = 13'd1;
		else if (n_sel < 34) n_val = 13'd2;
		else                 n_val = 13'($urandom_range(3, 48));
		if ($urandom_range(9) == 0)
			s_val = 13'($urandom);
		else
			s_val = 13'($urandom_range(0, (n_val > 4096 ? 4096 : n_val) + 3));
		if ($urandom_range(3) != 0) write_register(CFG_SAMPLING_MODE, 13'($urandom));
		if ($urandom_range(3) != 0) write_register(CFG_ITEM_COUNT, n_val);
		if ($urandom_range(3) != 0) write_register(CFG_SAMPLE_COUNT, s_val);
		if ($urandom_range(19) == 0) write_register(CFG_UNUSED, 13'($urandom));

		if ($urandom_range(99) < 80) begin
			// restart, draw toward exhaustion, then list the out-of-bag items
			send_request(ACT_RESTART, $urandom);
			limit = sb.draw_limit();
			cnt   = limit + $urandom_range(0, 2);
			if (cnt > 60) cnt = 60;
			repeat (cnt) begin
				if ($urandom_range(19) == 0)
					send_request(ACT_LIST, $urandom);
				else
					send_request(ACT_DRAW, pick_fraction());
			end
			if ($urandom_range(3) == 0) wait_for_idle();
			cnt = sb.missing + $urandom_range(0, 2);
			if (cnt > 40) cnt = 40;
			repeat (cnt) send_request(ACT_LIST, $urandom);
		end else begin
			// mixed actions without a leading restart
			repeat ($urandom_range(5, 40)) begin
				act_sel = $urandom_range(9);
				if (act_sel == 0)      action = ACT_RESTART;
				else if (act_sel == 1) action = ACT_UNKNOWN;
				else if (act_sel < 6)  action = ACT_DRAW;
				else                   action = ACT_LIST;
				send_request(action, pick_fraction());
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		burst_left = $urandom_range(1, 40);

		run_directed();
		while (items_sent < ITEM_TARGET) run_random_phase();

		// Drain, then give the last step time to finish
		wait_for_idle();
		repeat (300) @(posedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> files.f
+incdir+hdl
hdl/bsoob_pkg.sv
hdl/bsoob_ctrl.sv
hdl/bsoob_dpath.sv
hdl/bag_sampler_with_out_of_bag_core.sv
test/bag_sampler_scoreboard_pkg.sv
test/bag_sampler_with_out_of_bag_core_tb.sv
